[hw/rtl/pllds_pkg.sv]
// shared constants and types for the pll divider serial programmer
package pllds_pkg;
  localparam int REF_BITS = 14;
  localparam int MAIN_BITS = 11;
  localparam int SWALLOW_BITS = 7;
  localparam int REF_WORD_BITS = REF_BITS + 2;
  localparam int CNT_WORD_BITS = MAIN_BITS + SWALLOW_BITS + 1;
  localparam int RUN_BITS = REF_WORD_BITS + CNT_WORD_BITS;
  localparam logic [31:0] OSC_RESET = 32'd12800000;
  localparam logic [31:0] STEP_RESET = 32'd25000;
  localparam logic [7:0] MOD_32 = 8'd32;
  localparam logic [7:0] MOD_64 = 8'd64;
  localparam logic REG_OSC = 1'b0;
  localparam logic REG_STEP = 1'b1;

  typedef struct packed {
    logic [RUN_BITS-1:0] word;
    logic flag;
  } run_t;
endpackage

[hw/rtl/pll_divider_serial_programmer.sv]
// top level: divider pipeline, word assembly and serial shifter
//
// s_axis carries one request: target_freq and prescale_mod. Requests with
// a modulus other than 32 or 64 are dropped. Each valid request yields a
// run of 35 serial transfers on m_axis: the 16-bit reference word
// {prescaler, R[13:0], 1} then the 19-bit counter word {N, A, 0}, msb
// first. latch_after marks the control bit ending each word, last marks
// bit 34, range_flag is set on every bit when R or N overflows its field.
// R and q come from two 32-stage one-bit-per-stage divider pipelines that
// advance together. Requests flow into the pipeline every cycle while it
// is not stalled; the serial shifter emits one bit per cycle while the
// receiver is ready, so the shifter sets the sustained request rate. The
// pipeline stalls only when its last stage and the holding slot are both
// full, so a stalled receiver holds everything with nothing lost. Reset
// (rst, synchronous) empties the pipeline and restores osc_freq 12800000
// and step_freq 25000.
// cfg writes take effect on the next request and must be made while idle.
module pll_divider_serial_programmer
  import pllds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // target_freq[31:0], prescale_mod[39:32]
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  output logic [7:0] m_axis_tdata,   // data_bit[0], latch_after[1], range_flag[2], zero pad
  output logic m_axis_tlast
);
  logic [31:0] osc_freq;
  logic [31:0] step_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      osc_freq <= OSC_RESET;
      step_freq <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OSC:  osc_freq <= cfg_data;
        REG_STEP: step_freq <= cfg_data;
        default: ;
      endcase
    end
  end

  logic hold_full;
  logic advance;
  logic d_valid;
  logic [31:0] q;
  logic [7:0] md;
  logic in_ok;

  assign in_ok = (s_axis_tdata[39:32] == MOD_32) || (s_axis_tdata[39:32] == MOD_64);
  assign advance = !(d_valid && hold_full);
  assign s_axis_tready = advance;

  pllds_divider u_qdiv (
    .clk, .rst, .advance,
    .in_valid(s_axis_tvalid && in_ok),
    .dividend(s_axis_tdata[31:0]), .divisor(step_freq), .mod_in(s_axis_tdata[39:32]),
    .out_valid(d_valid), .quotient(q), .mod_out(md)
  );

  // R divider runs in lock step with the request divider
  logic [31:0] r_q;
  logic r_vld;
  logic [7:0] r_md_unused;
  pllds_divider u_rdiv (
    .clk, .rst, .advance,
    .in_valid(s_axis_tvalid && in_ok),
    .dividend(osc_freq), .divisor(step_freq), .mod_in(8'd0),
    .out_valid(r_vld), .quotient(r_q), .mod_out(r_md_unused)
  );

  // assemble run word
  run_t hold;
  run_t asm_run;
  logic [31:0] n_full;
  logic [5:0] a_val;
  logic pbit;
  always_comb begin
    pbit = (md == MOD_32);
    n_full = pbit ? {5'd0, q[31:5]} : {6'd0, q[31:6]};
    a_val = pbit ? {1'b0, q[4:0]} : q[5:0];
    asm_run.word = {pbit, r_q[REF_BITS-1:0], 1'b1,
                    n_full[MAIN_BITS-1:0], 1'b0, a_val, 1'b0};
    asm_run.flag = (r_q[31:REF_BITS] != '0) || (n_full[31:MAIN_BITS] != '0);
  end

  // serial shifter with one-entry holding slot
  logic shifting;
  logic [RUN_BITS-1:0] sh;
  logic sh_flag;
  logic [5:0] pos;
  logic take;
  assign take = m_axis_tvalid && m_axis_tready;
  logic done;
  assign done = take && (pos == 6'(RUN_BITS-1));

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_full <= 1'b0;
      shifting <= 1'b0;
      pos <= '0;
    end else begin
      if (d_valid && !hold_full) begin
        hold_full <= 1'b1;
        hold <= asm_run;
      end else if (hold_full && (!shifting || done)) begin
        hold_full <= 1'b0;
      end
      if (hold_full && (!shifting || done)) begin
        shifting <= 1'b1;
        sh <= hold.word;
        sh_flag <= hold.flag;
        pos <= '0;
      end else if (done) begin
        shifting <= 1'b0;
        pos <= '0;
      end else if (take) begin
        sh <= {sh[RUN_BITS-2:0], 1'b0};
        pos <= pos + 6'd1;
      end
    end
  end

  assign m_axis_tvalid = shifting;
  assign m_axis_tlast = (pos == 6'(RUN_BITS-1));
  assign m_axis_tdata = {5'd0, sh_flag,
                         (pos == 6'(REF_WORD_BITS-1)) || m_axis_tlast,
                         sh[RUN_BITS-1]};

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= 6'(RUN_BITS-1)) else $error("bit position out of range");
  a_idle_pos: assert property (@(posedge clk) disable iff (rst)
    !shifting |-> pos == '0) else $error("position not cleared");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (hold_full && shifting && !done) |=> hold_full) else $error("slot lost");
  a_div_align: assert property (@(posedge clk) disable iff (rst)
    r_vld == d_valid) else $error("dividers out of step");
endmodule

[hw/rtl/pllds_divider.sv]
// radix-2 restoring divider, one quotient bit per stage, fully pipelined
module pllds_divider
  import pllds_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic advance,
  input  logic in_valid,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  input  logic [7:0] mod_in,
  output logic out_valid,
  output logic [31:0] quotient,
  output logic [7:0] mod_out
);
  localparam int STAGES = 32;

  logic vld [STAGES+1];
  logic [31:0] rem [STAGES+1];
  logic [31:0] quo [STAGES+1];
  logic [31:0] dvs [STAGES+1];
  logic [7:0] md [STAGES+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign quo[0] = dividend;
  assign dvs[0] = divisor;
  assign md[0] = mod_in;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [32:0] trial;
    logic [32:0] shifted;
    assign shifted = {rem[s], quo[s][31]};
    assign trial = shifted - {1'b0, dvs[s]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (advance) begin
        vld[s+1] <= vld[s];
      end
      if (advance) begin
        if (!trial[32]) begin
          rem[s+1] <= trial[31:0];
          quo[s+1] <= {quo[s][30:0], 1'b1};
        end else begin
          rem[s+1] <= shifted[31:0];
          quo[s+1] <= {quo[s][30:0], 1'b0};
        end
        dvs[s+1] <= dvs[s];
        md[s+1] <= md[s];
      end
    end
  end

  // divide by zero gives all ones naturally in restoring form
  assign out_valid = vld[STAGES];
  assign quotient = quo[STAGES];
  assign mod_out = md[STAGES];
endmodule

[tb/pll_divider_serial_programmer_tb.sv]
// testbench for the pll divider serial programmer: predicts each serial run and checks it
module pll_divider_serial_programmer_tb;
  import pllds_pkg::*;

  typedef struct packed {
    logic data_bit;
    logic latch_after;
    logic range_flag;
    logic last;
  } serial_bit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_OSC;
  logic [31:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;  // target_freq[31:0], prescale_mod[39:32]
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;        // data_bit[0], latch_after[1], range_flag[2], zero pad
  logic m_axis_tlast;

  logic [31:0] osc_freq = OSC_RESET;
  logic [31:0] step_freq = STEP_RESET;
  serial_bit_t expected_bits[$];
  int errors = 0;

  always #2 clk = ~clk;

  pll_divider_serial_programmer i_dut (.*);

  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
    return (b == 0) ? 32'hFFFF_FFFF : a / b;
  endfunction

  // queue the 35 bits that one request produces
  task automatic predict_run(logic [31:0] freq, logic [7:0] modulus);
    logic [31:0] r, q, n, a;
    logic flag;
    logic [REF_WORD_BITS-1:0] ref_word;
    logic [CNT_WORD_BITS-1:0] count_word;
    if (modulus != MOD_32 && modulus != MOD_64) return;
    r = quotient(osc_freq, step_freq);
    q = quotient(freq, step_freq);
    n = q / modulus;
    a = q % modulus;
    flag = (r >> REF_BITS) != 0 || (n >> MAIN_BITS) != 0;
    ref_word = {modulus == MOD_32, r[REF_BITS-1:0], 1'b1};
    count_word = {n[MAIN_BITS-1:0], a[SWALLOW_BITS-1:0], 1'b0};
    for (int i = REF_WORD_BITS - 1; i >= 0; i--)
      expected_bits.push_back('{ref_word[i], i == 0, flag, 1'b0});
    for (int i = CNT_WORD_BITS - 1; i >= 0; i--)
      expected_bits.push_back('{count_word[i], i == 0, flag, i == 0});
  endtask

  task automatic send_request(logic [31:0] freq, logic [7:0] modulus);
    int gap;
    gap = $urandom_range(0, 18) * ($urandom_range(0, 3) == 0);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {modulus, freq};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    predict_run(freq, modulus);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_bits.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(logic index, logic [31:0] value);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == REG_OSC) osc_freq = value;
    else step_freq = value;
  endtask

  function automatic logic [7:0] random_mod();
    case ($urandom_range(0, 9))
      0: return 8'($urandom);
      1, 2, 3, 4: return MOD_32;
      default: return MOD_64;
    endcase
  endfunction

  task automatic test_directed();
    send_request(32'd145_000_000, MOD_32);
    send_request(32'd145_000_000, MOD_64);
    send_request(32'd0, MOD_32);
    send_request(32'hFFFF_FFFF, MOD_64);
    send_request(32'hFFFF_FFFF, MOD_32);
    send_request(32'd12345, 8'd0);
    send_request(32'd12345, 8'd255);
    send_request(32'd12345, 8'd33);
    send_request(32'd1_638_375_000, MOD_64);
    send_request(32'd1_638_400_000, MOD_64);
    send_request(32'd819_175_000, MOD_32);
    send_request(32'd819_200_000, MOD_32);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    write_reg(REG_OSC, 32'd409_575_000);
    send_request(32'd100_000_000, MOD_32);
    write_reg(REG_OSC, 32'd409_600_000);
    send_request(32'd100_000_000, MOD_64);
    write_reg(REG_STEP, 32'd1);
    write_reg(REG_OSC, 32'd1);
    send_request(32'd2047, MOD_32);
    send_request(32'hFFFF_FFFF, MOD_64);
    write_reg(REG_STEP, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, MOD_32);
    write_reg(REG_OSC, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFE, MOD_64);
    write_reg(REG_STEP, 32'd0);
    send_request(32'd5, MOD_32);
    wait_idle();
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 90 == 0) begin
        case ($urandom_range(0, 2))
          0: write_reg(REG_STEP, STEP_RESET);
          1: write_reg(REG_STEP, $urandom_range(1, 200_000));
          default: write_reg(REG_STEP, $urandom);
        endcase
        write_reg(REG_OSC, $urandom_range(0, 1) ? $urandom : $urandom_range(1, 400_000_000));
      end
      if (i % 50 == 25) wait_idle();
      send_request($urandom_range(0, 1) ? $urandom : $urandom_range(0, 200_000_000),
                   random_mod());
    end
  endtask

  // receiver stalls
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk);
      while (!(m_axis_tvalid && m_axis_tready)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    serial_bit_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[2], m_axis_tlast};
      if (expected_bits.size() == 0) begin
        $display("%0t unexpected transfer %b", $time, got);
        errors++;
      end else begin
        want = expected_bits.pop_front();
        if (got !== want || m_axis_tdata[7:3] !== 5'b0) begin
          $display("%0t mismatch expected %b actual %b (tdata %h)", $time, want, got,
                   m_axis_tdata);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_extremes();
    test_random(430);
    wait_idle();
    if (errors == 0 && expected_bits.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

[sim.f]
hw/rtl/pllds_pkg.sv
hw/rtl/pllds_divider.sv
hw/rtl/pll_divider_serial_programmer.sv
tb/pll_divider_serial_programmer_tb.sv
